FILE: rtl/core/stbs_pkg.sv
// Package for the sorted-table binary search block.
// Holds table sizing, command codes, the queued word type and the search states.
// No dependencies.
package stbs_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LEN_W  = IDX_W + 1;
  localparam int SW     = LEN_W + 1;
  localparam int DATA_W = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     search;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/stbs_front.sv
// Front end: accepts input words, classifies them as load or search,
// and queues them for the search engine. Depends on stbs_pkg.
module stbs_front import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] value,
  output logic                     q_valid,
  output item_t                    q_item,
  input  logic                     q_pop
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             incoming;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    incoming.search = (cmd == CMD_SEARCH);
    incoming.idx    = entry_index;
    incoming.value  = value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/stbs_back.sv
// Back end: table memory and the iterative binary search, one probe a cycle,
// with a registered result word. Depends on stbs_pkg.
module stbs_back import stbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic [LEN_W-1:0] table_length,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [IDX_W-1:0] position
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic [IDX_W-1:0]         rd_addr;

  state_t                   state;
  state_t                   state_next;
  logic signed [SW-1:0]     low;
  logic signed [SW-1:0]     high;
  logic [IDX_W-1:0]         mid;
  logic signed [DATA_W-1:0] key;
  logic                     res_found;
  logic [IDX_W-1:0]         res_pos;

  logic [LEN_W-1:0]         len_sat;
  logic signed [SW-1:0]     start_high;
  logic signed [SW-1:0]     mid_ext;
  logic signed [SW-1:0]     low_gt;
  logic signed [SW-1:0]     high_lt;
  logic signed [SW-1:0]     low_n;
  logic signed [SW-1:0]     high_n;
  logic signed [SW:0]       sum_gt;
  logic signed [SW:0]       sum_lt;
  logic [IDX_W-1:0]         mid_n;
  logic                     eq;
  logic                     gt;
  logic                     empty_n;
  logic                     out_free;

  assign len_sat    = (table_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : table_length;
  assign start_high = $signed({1'b0, len_sat}) - $signed(SW'(1));
  assign mid_ext    = $signed({{(SW-IDX_W){1'b0}}, mid});
  assign low_gt     = mid_ext + $signed(SW'(1));
  assign high_lt    = mid_ext - $signed(SW'(1));
  assign eq         = (key == rdata);
  assign gt         = (key > rdata);
  assign sum_gt     = (SW+1)'(low_gt) + (SW+1)'(high);
  assign sum_lt     = (SW+1)'(low) + (SW+1)'(high_lt);
  assign low_n      = gt ? low_gt : low;
  assign high_n     = gt ? high : high_lt;
  assign mid_n      = gt ? sum_gt[IDX_W:1] : sum_lt[IDX_W:1];
  assign empty_n    = (low_n > high_n);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.search) begin
          state_next = (len_sat == '0) ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (eq || empty_n) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    rd_addr = mid_n;
    case (state)
      ST_IDLE: begin
        q_pop   = q_valid;
        rd_addr = start_high[IDX_W:1];
      end
      ST_PROBE:  rd_addr = mid_n;
      ST_FINISH: rd_addr = mid;
      default:   rd_addr = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.search) begin
      mem[q_item.idx] <= q_item.value;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        low       <= '0;
        high      <= start_high;
        mid       <= start_high[IDX_W:1];
        key       <= q_item.value;
        res_found <= 1'b0;
        res_pos   <= '0;
      end
      ST_PROBE: begin
        if (eq) begin
          res_found <= 1'b1;
          res_pos   <= mid;
        end else begin
          low  <= low_n;
          high <= high_n;
          mid  <= mid_n;
        end
      end
      default: begin
        mid <= mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

endmodule

FILE: rtl/core/sorted_table_binary_search_top.sv
// Sorted-table binary search, top level: length register, front queue, search engine.
// A load word is written to the table when the engine takes it; a search makes P <= 11
// probes at 1024 entries, one table read per probe; result word registered at the output.
// Up to two words queue ahead of the engine, so loads keep flowing while a result waits.
// Reset (synchronous, active high) empties the queue and output and sets table_length
// to 0; table contents are undefined until loaded. Depends on stbs_pkg.
module sorted_table_binary_search_top import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [LEN_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     found,
  output logic [IDX_W-1:0]         position
);

  logic [LEN_W-1:0] table_length;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_wr_en) begin
      table_length <= cfg_wr_data;
    end
  end

  stbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .entry_index (entry_index),
    .value       (value),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  stbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .table_length (table_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .position     (position)
  );

endmodule

FILE: rtl/core/stbs_checker.sv
// Port-level checks for the sorted-table binary search top level, with its bind.
// Depends on stbs_pkg.
module stbs_checker import stbs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             found,
  input logic [IDX_W-1:0] position
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
    else $error("stalled result word changed");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("not-found result with nonzero position");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  a_rst_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind sorted_table_binary_search_top stbs_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .position  (position)
);

FILE: tb/tb_sorted_table_binary_search_top.sv
// Self-checking testbench for sorted_table_binary_search_top: loads table words, runs
// searches at several table lengths and checks every result word against a local model.
// Depends on stbs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_sorted_table_binary_search_top;
  import stbs_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int SETTLE       = 32;
  localparam int LIMIT        = 2000000;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_answer_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = CMD_LOAD;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [IDX_W-1:0]         position;

  sorted_table_binary_search_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .entry_index (entry_index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position)
  );

  // model state, advanced as words are accepted
  logic signed [DATA_W-1:0] shadow_table [DEPTH];
  logic [LEN_W-1:0]         length_setting = '0;
  search_answer_t           expected_results [$];

  // table image as seen by the stimulus generator
  logic signed [DATA_W-1:0] plan_table [DEPTH];
  bit                       plan_written [DEPTH];

  item_t pending_words [$];
  item_t word_on_bus;
  int    words_queued = 0;
  int    words_done = 0;
  int    random_words = 0;
  int    failures = 0;
  int    cycle_count = 0;
  int    send_gap = 0;
  int    stall_left = 0;
  int    stall_len;
  bit    held;
  bit    calm = 1'b0;
  search_answer_t got, want;

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_table[i] = '0;
      plan_table[i] = '0;
      plan_written[i] = 1'b0;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic search_answer_t search_shadow(logic signed [DATA_W-1:0] key);
    search_answer_t ans;
    int lo, hi, mid, span;
    bit hit;
    span = (length_setting > DEPTH) ? DEPTH : int'(length_setting);
    lo = 0;
    hi = span - 1;
    hit = 1'b0;
    ans = '0;
    while (!hit && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key == shadow_table[mid]) begin
        hit = 1'b1;
        ans.found = 1'b1;
        ans.position = mid[IDX_W-1:0];
      end else if (key > shadow_table[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return ans;
  endfunction

  task automatic apply_word(item_t w);
    if (w.search == CMD_SEARCH) expected_results.push_back(search_shadow(w.value));
    else shadow_table[w.idx] = w.value;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        apply_word(word_on_bus);
        words_done++;
      end
      if (!held) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          in_valid <= 1'b1;
          cmd <= (word_on_bus.search == CMD_SEARCH) ? CMD_SEARCH : CMD_LOAD;
          entry_index <= word_on_bus.idx;
          value <= word_on_bus.value;
          send_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.found = found;
        got.position = position;
        if (expected_results.size() == 0) begin
          $error("result word with no search pending: found %0d position %0d",
                 got.found, got.position);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            failures++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_len = idle_len();
        out_stall <= (stall_len > 0);
        stall_left = (stall_len > 0) ? stall_len - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_sorted_table_binary_search_top: done, errors");
      $finish;
    end
  end

  task automatic queue_word(logic is_search, int idx, logic signed [DATA_W-1:0] v);
    item_t w;
    w.search = is_search;
    w.idx = idx[IDX_W-1:0];
    w.value = v;
    if (is_search == CMD_LOAD) begin
      plan_table[idx] = v;
      plan_written[idx] = 1'b1;
    end
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_idle();
    while (words_done != words_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(int len);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len[LEN_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_setting = len[LEN_W-1:0];
  endtask

  task automatic fill_table(int span, bit sorted);
    longint acc, step_max;
    step_max = 64'd4294967295 / (span + 1);
    if ($urandom_range(0, 9) < 3) step_max = 3;
    acc = -64'sd2147483648 + $urandom_range(0, int'(step_max));
    for (int i = 0; i < span; i++) begin
      if (sorted) begin
        queue_word(CMD_LOAD, i, acc[DATA_W-1:0]);
        acc += $urandom_range(0, int'(step_max));
      end else begin
        queue_word(CMD_LOAD, i, $urandom);
      end
    end
  endtask

  // sorted words at every sixteenth entry cover the upper levels of the full-depth search
  task automatic fill_sparse();
    longint acc;
    acc = -64'sd2147483648 + $urandom_range(0, 1000);
    for (int i = 15; i < DEPTH; i += 16) begin
      queue_word(CMD_LOAD, i, acc[DATA_W-1:0]);
      acc += $urandom_range(1, 66000000);
    end
  endtask

  // true when every entry the search would probe has been loaded
  function automatic bit path_written(logic signed [DATA_W-1:0] key, int span);
    int lo, hi, mid;
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!plan_written[mid]) return 1'b0;
      if (key == plan_table[mid]) return 1'b1;
      if (key > plan_table[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key(int span);
    int r;
    logic signed [DATA_W-1:0] k;
    for (int t = 0; t < 40; t++) begin
      r = $urandom_range(0, 99);
      if (span == 0 || r >= 80) begin
        k = $urandom;
      end else begin
        k = plan_table[$urandom_range(0, span - 1)];
        if (r >= 60) k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end
      if (path_written(k, span)) return k;
    end
    return plan_table[(span - 1) / 2];
  endfunction

  initial begin
    int len, span, count, r, idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    queue_word(CMD_SEARCH, 0, 32'sh8000_0000);

    queue_word(CMD_LOAD, 0, 32'sh8000_0000);
    queue_word(CMD_LOAD, 1, -1000);
    queue_word(CMD_LOAD, 2, -1);
    queue_word(CMD_LOAD, 3, 0);
    queue_word(CMD_LOAD, 4, 1);
    queue_word(CMD_LOAD, 5, 5);
    queue_word(CMD_LOAD, 6, 5);
    queue_word(CMD_LOAD, 7, 32'sh7FFF_FFFF);
    queue_word(CMD_LOAD, DEPTH - 1, 32'sh5555_5555);
    write_length(8);
    queue_word(CMD_SEARCH, 0, 32'sh8000_0000);
    queue_word(CMD_SEARCH, 0, 32'sh7FFF_FFFF);
    queue_word(CMD_SEARCH, 0, 0);
    queue_word(CMD_SEARCH, 0, 5);
    queue_word(CMD_SEARCH, 0, -1);
    queue_word(CMD_SEARCH, 0, 2);
    queue_word(CMD_SEARCH, 0, 32'sh8000_0001);
    queue_word(CMD_SEARCH, 0, 32'sh7FFF_FFFE);
    write_length(1);
    queue_word(CMD_SEARCH, 0, 32'sh8000_0000);
    queue_word(CMD_SEARCH, 0, 0);

    for (int phase = 0; random_words < RANDOM_WORDS; phase++) begin
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 2) len = DEPTH;
      else if (phase == 5) len = 2047;
      else if (phase == 8) len = DEPTH + 1;
      else begin
        r = $urandom_range(0, 99);
        if (r < 5) len = 0;
        else if (r < 25) len = $urandom_range(1, 4);
        else if (r < 85) len = $urandom_range(5, 64);
        else len = $urandom_range(65, 300);
      end
      span = (len > DEPTH) ? DEPTH : len;
      write_length(len);
      if (phase == 2) begin
        fill_sparse();
        random_words += DEPTH / 16;
      end else if (len < DEPTH) begin
        fill_table(span, $urandom_range(0, 4) != 0);
        random_words += span;
      end
      count = $urandom_range(10, 40);
      for (int k = 0; k < count; k++) begin
        // hold the sender until the block has drained
        if (phase == 1 && k == count / 2) wait_idle();
        if ($urandom_range(0, 3) != 0) begin
          queue_word(CMD_SEARCH, 0, pick_key(span));
        end else begin
          if (span < DEPTH && $urandom_range(0, 1)) idx = $urandom_range(span, DEPTH - 1);
          else idx = $urandom_range(0, DEPTH - 1);
          queue_word(CMD_LOAD, idx, $urandom);
        end
        random_words++;
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("tb_sorted_table_binary_search_top: done, clean");
    end else begin
      $display("tb_sorted_table_binary_search_top: done, errors");
    end
    $finish;
  end

endmodule
